// ===== hdl/weighted_vote_argmax_per_slot_defines.svh =====
// Assertion macros used by the weighted vote block checker.
`ifndef WEIGHTED_VOTE_ARGMAX_PER_SLOT_DEFINES_SVH
`define WEIGHTED_VOTE_ARGMAX_PER_SLOT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WVAM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define WVAM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/wvam_pkg.sv =====
// Constants, types and helpers for the weighted vote argmax block.
package wvam_pkg;

    localparam int SLOT_W     = 4;
    localparam int GOAL_W     = 4;
    localparam int WEIGHT_W   = 17;
    localparam int COUNT_W    = 5;
    localparam int ACC_W      = 32;
    localparam int SUM_W      = ACC_W + 1;
    localparam int RESULT_CAP = 16;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    localparam int MAX_SLOTS_DEF  = 16;
    localparam int MAX_GOALS_DEF  = 16;
    localparam int SCAN_GOALS_DEF = 7;

    localparam logic CMD_ACCUMULATE = 1'b0;
    localparam logic CMD_FINISH     = 1'b1;

    typedef logic [ACC_W-1:0]    acc_t;
    typedef logic [WEIGHT_W-1:0] weight_t;

    // Saturating accumulate.
    function automatic acc_t sat_add(acc_t cur, weight_t w);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, cur} + SUM_W'(w);
        return sum[ACC_W] ? '1 : sum[ACC_W-1:0];
    endfunction

endpackage

// ===== hdl/weighted_vote_argmax_per_slot.sv =====
// Weighted vote table with per-slot argmax readout.
//
// Input stream (s_axis): tuser is the command, accumulate or finish. An accumulate
// request adds vote_weight into the table entry of (slot_index, goal_index) with
// saturation; it gives no result. A finish request reports one winner per slot
// below min(slot_count, MAX_SLOTS, 16) on m_axis, tlast on the final one, then
// clears the table. With no vote since the last finish, or a zero count, it only clears.
// Throughput: accumulates go one per cycle; the table sits in one synchronous RAM
// and each vote is a read-modify-write with the previous write forwarded.
// A finish scans the row of each reported slot through the single read port, over
// the first min(SCAN_GOALS, MAX_GOALS) goals, then runs a clearing pass over all
// MAX_SLOTS * MAX_GOALS entries (256 by default) that writes one entry a cycle.
// s_axis_tready is low for the whole finish and clearing pass.
// Reset: the same clearing pass runs first; the block takes no request until it ends.
// Stall: a result waits in the output register; the next row is scanned, then the
// block holds until the waiting result is taken.
module weighted_vote_argmax_per_slot #(
    parameter int MAX_SLOTS  = wvam_pkg::MAX_SLOTS_DEF,
    parameter int MAX_GOALS  = wvam_pkg::MAX_GOALS_DEF,
    parameter int SCAN_GOALS = wvam_pkg::SCAN_GOALS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // slot_index[3:0], goal_index[7:4], vote_weight[24:8], slot_count[29:25], zero pad
    input  logic [wvam_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // command
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // result_slot[3:0], winning_goal[7:4]
    output logic [wvam_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // last_result
    output logic                           m_axis_tlast
);

    localparam int DEPTH    = MAX_SLOTS * MAX_GOALS;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SCAN_N   = (SCAN_GOALS < MAX_GOALS) ? SCAN_GOALS : MAX_GOALS;
    localparam int CAP_N    = (MAX_SLOTS < wvam_pkg::RESULT_CAP) ? MAX_SLOTS
                                                                 : wvam_pkg::RESULT_CAP;
    localparam logic [ADDR_W-1:0]              CLR_LAST  = ADDR_W'(DEPTH - 1);
    localparam logic [wvam_pkg::GOAL_W-1:0]    SCAN_LAST = wvam_pkg::GOAL_W'(SCAN_N - 1);
    localparam logic [wvam_pkg::COUNT_W-1:0]   CAP_CNT   = wvam_pkg::COUNT_W'(CAP_N);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_SETTLE = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0] state_reg, state_next;

    // input fields
    logic [wvam_pkg::SLOT_W-1:0]  in_slot;
    logic [wvam_pkg::GOAL_W-1:0]  in_goal;
    wvam_pkg::weight_t            in_weight;
    logic [wvam_pkg::COUNT_W-1:0] in_count;
    logic [wvam_pkg::COUNT_W-1:0] cnt_lim;
    logic                         in_range;
    logic [ADDR_W-1:0]            in_addr;
    logic                         in_accept;
    logic                         acc_accept;
    logic                         fin_accept;

    // table memory
    wvam_pkg::acc_t    vote_mem [DEPTH];
    wvam_pkg::acc_t    rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    wvam_pkg::acc_t    mem_wdata;

    // accumulate pipeline
    logic              s1_valid_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    wvam_pkg::weight_t s1_weight_reg;
    logic              w_valid_reg;
    logic [ADDR_W-1:0] w_addr_reg;
    wvam_pkg::acc_t    w_data_reg;
    wvam_pkg::acc_t    acc_cur;
    wvam_pkg::acc_t    acc_sum;

    logic              seen_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // scan
    logic [wvam_pkg::COUNT_W-1:0] count_reg;
    logic [wvam_pkg::SLOT_W-1:0]  slot_reg;
    logic [wvam_pkg::GOAL_W-1:0]  goal_reg;
    logic [ADDR_W-1:0]            scan_addr;
    logic                         scan_rd_valid_reg;
    logic [wvam_pkg::GOAL_W-1:0]  rd_goal_reg;
    wvam_pkg::acc_t               best_val_reg;
    logic [wvam_pkg::GOAL_W-1:0]  best_goal_reg;
    logic                         row_last;

    // output register
    logic                         out_valid_reg;
    logic [wvam_pkg::SLOT_W-1:0]  out_slot_reg;
    logic [wvam_pkg::GOAL_W-1:0]  out_goal_reg;
    logic                         out_last_reg;
    logic                         out_load;

    assign in_slot   = s_axis_tdata[3:0];
    assign in_goal   = s_axis_tdata[7:4];
    assign in_weight = s_axis_tdata[24:8];
    assign in_count  = s_axis_tdata[29:25];

    assign in_range  = (int'(in_slot) < MAX_SLOTS) && (int'(in_goal) < MAX_GOALS);
    assign in_addr   = ADDR_W'(int'(in_slot) * MAX_GOALS + int'(in_goal));
    assign cnt_lim   = (in_count > CAP_CNT) ? CAP_CNT : in_count;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign acc_accept    = in_accept && (s_axis_tuser == wvam_pkg::CMD_ACCUMULATE) && in_range;
    assign fin_accept    = in_accept && (s_axis_tuser == wvam_pkg::CMD_FINISH);

    assign scan_addr = ADDR_W'(int'(slot_reg) * MAX_GOALS + int'(goal_reg));
    assign rd_addr   = (state_reg == S_SCAN) ? scan_addr : in_addr;

    // forward the write of the previous cycle, which the RAM read missed
    assign acc_cur = (w_valid_reg && (w_addr_reg == s1_addr_reg)) ? w_data_reg : rd_data_reg;
    assign acc_sum = wvam_pkg::sat_add(acc_cur, s1_weight_reg);

    assign mem_we    = s1_valid_reg || (state_reg == S_CLEAR);
    assign mem_waddr = s1_valid_reg ? s1_addr_reg : clr_addr_reg;
    assign mem_wdata = s1_valid_reg ? acc_sum : '0;

    assign row_last = (({1'b0, slot_reg} + wvam_pkg::COUNT_W'(1)) == count_reg);
    assign out_load = (state_reg == S_EMIT) && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk)
    begin
        rd_data_reg <= vote_mem[rd_addr];
        if (mem_we)
        begin
            vote_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (fin_accept)
                begin
                    state_next = (seen_reg && (cnt_lim != '0)) ? S_SCAN : S_CLEAR;
                end
            end
            S_SCAN:
            begin
                if (goal_reg == SCAN_LAST)
                begin
                    state_next = S_SETTLE;
                end
            end
            S_SETTLE:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    state_next = row_last ? S_CLEAR : S_SCAN;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            clr_addr_reg      <= '0;
            seen_reg          <= 1'b0;
            s1_valid_reg      <= 1'b0;
            w_valid_reg       <= 1'b0;
            scan_rd_valid_reg <= 1'b0;
            count_reg         <= '0;
            slot_reg          <= '0;
            goal_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            s1_valid_reg      <= acc_accept;
            w_valid_reg       <= s1_valid_reg;
            scan_rd_valid_reg <= (state_reg == S_SCAN);

            if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= (clr_addr_reg == CLR_LAST) ? '0 : clr_addr_reg + ADDR_W'(1);
            end

            if (acc_accept)
            begin
                seen_reg <= 1'b1;
            end
            else if (fin_accept)
            begin
                seen_reg <= 1'b0;
            end

            if (fin_accept)
            begin
                count_reg <= cnt_lim;
                slot_reg  <= '0;
                goal_reg  <= '0;
            end
            else if (state_reg == S_SCAN)
            begin
                goal_reg <= (goal_reg == SCAN_LAST) ? '0 : goal_reg + wvam_pkg::GOAL_W'(1);
            end
            else if (out_load && !row_last)
            begin
                slot_reg <= slot_reg + wvam_pkg::SLOT_W'(1);
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (acc_accept)
        begin
            s1_addr_reg   <= in_addr;
            s1_weight_reg <= in_weight;
        end
        if (s1_valid_reg)
        begin
            w_addr_reg <= s1_addr_reg;
            w_data_reg <= acc_sum;
        end
        rd_goal_reg <= goal_reg;
        // strict compare keeps the lowest goal on a tie
        if (scan_rd_valid_reg && ((rd_goal_reg == '0) || (rd_data_reg > best_val_reg)))
        begin
            best_val_reg  <= rd_data_reg;
            best_goal_reg <= rd_goal_reg;
        end
        if (out_load)
        begin
            out_slot_reg <= slot_reg;
            out_goal_reg <= best_goal_reg;
            out_last_reg <= row_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_goal_reg, out_slot_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== hdl/wvam_checker.sv =====
// Port-level checker for the weighted vote argmax block, with its bind.
`include "weighted_vote_argmax_per_slot_defines.svh"

module wvam_checker #(
    parameter int MAX_SLOTS  = wvam_pkg::MAX_SLOTS_DEF,
    parameter int MAX_GOALS  = wvam_pkg::MAX_GOALS_DEF,
    parameter int SCAN_GOALS = wvam_pkg::SCAN_GOALS_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [wvam_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic                           s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [wvam_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tlast
);

    localparam int SCAN_N = (SCAN_GOALS < MAX_GOALS) ? SCAN_GOALS : MAX_GOALS;

    `WVAM_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

    // results only come out of a finish, never while requests are taken
    `WVAM_ASSERT_NOW(a_result_not_idle, clk, rst_n, $rose(m_axis_tvalid), !$past(s_axis_tready), "result appeared while idle")

    `WVAM_ASSERT_NOW(a_goal_range, clk, rst_n, m_axis_tvalid, int'(m_axis_tdata[7:4]) < SCAN_N, "winning goal outside scan")

    `WVAM_ASSERT_NOW(a_slot_range, clk, rst_n, m_axis_tvalid, int'(m_axis_tdata[3:0]) < MAX_SLOTS, "result slot out of range")

endmodule

bind weighted_vote_argmax_per_slot wvam_checker #(
    .MAX_SLOTS  (MAX_SLOTS),
    .MAX_GOALS  (MAX_GOALS),
    .SCAN_GOALS (SCAN_GOALS)
) u_wvam_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
